/* src/jppc_pkg.sv */
// Package for the JSON pretty-print colorizer: result kinds, colors,
// character codes, and the command record passed from front to back.
// No dependencies.
package jppc_pkg;

    localparam int MAX_RESULTS = 4;
    localparam int SLOT_IW     = $clog2(MAX_RESULTS);
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int APB_AW      = 3;

    localparam logic REG_ORIG_ATTR = 1'b0;

    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_CRLF   = 2'd1;
    localparam logic [1:0] KIND_INDENT = 2'd2;
    localparam logic [1:0] KIND_ATTR   = 2'd3;

    localparam logic [6:0] COL_KEY     = 7'h03;
    localparam logic [6:0] COL_STRING  = 7'h02;
    localparam logic [6:0] COL_NUMBER  = 7'h0E;
    localparam logic [6:0] COL_LITERAL = 7'h05;
    localparam logic [6:0] COL_PUNCT   = 7'h07;
    localparam logic [6:0] ORIG_ATTR_RESET = 7'h07;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] val;
    } t_slot;

    typedef struct packed {
        logic [SLOT_IW-1:0]            last_idx;
        t_slot [MAX_RESULTS-1:0]       slots;
    } t_cmd;

    function automatic t_slot mk_slot(logic [1:0] kind, logic [7:0] val);
        t_slot s;
        s.kind = kind;
        s.val  = val;
        return s;
    endfunction

    function automatic t_slot mk_attr(logic [6:0] col);
        return mk_slot(KIND_ATTR, {1'b0, col});
    endfunction

endpackage

/* src/jppc_if.sv */
// Stream interfaces for the JSON pretty-print colorizer: input bytes and
// console command results. No dependencies.
interface jppc_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] text_byte;

    modport source (output valid, output op, output text_byte, input ready);
    modport sink   (input valid, input op, input text_byte, output ready);
endinterface

interface jppc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_char;
    logic [7:0] indent_units;
    logic [6:0] attribute;
    logic       last_of_run;

    modport source (output valid, output kind, output out_char, output indent_units,
                    output attribute, output last_of_run, input ready);
    modport sink   (input valid, input kind, input out_char, input indent_units,
                    input attribute, input last_of_run, output ready);
endinterface

/* src/jppc_front.sv */
// Front end: accepts JSON bytes, tracks parse state and container stack,
// and builds at most one command of up to four results per byte. Uses jppc_pkg, jppc_in_if.
module jppc_front #(
    parameter int STACK_DEPTH = 64,
    parameter int DEPTH_LIMIT = 255
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    jppc_in_if.sink             i_in,
    input  logic [6:0]          i_orig_attr,
    input  logic                i_q_full,
    output logic                o_q_push,
    output jppc_pkg::t_cmd      o_q_cmd
);
    import jppc_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int DW = $clog2(DEPTH_LIMIT + 1) + 1;
    localparam logic signed [DW-1:0] LIM  = DW'(DEPTH_LIMIT);
    localparam logic        [CW-1:0] FULL = CW'(STACK_DEPTH);

    logic                 r_in_quoted, n_in_quoted;
    logic                 r_after_bs,  n_after_bs;
    logic                 r_key_exp,   n_key_exp;
    logic                 r_seen,      n_seen;
    logic signed [DW-1:0] r_depth,     n_depth;
    logic [CW-1:0]        r_count,     n_count;
    logic                 r_top,       n_top;
    logic                 r_below;
    logic                 mem [STACK_DEPTH];

    logic          fire;
    logic          stk_push;
    logic          is_obj;
    logic [7:0]    b;
    logic [CW-1:0] below_idx;
    logic [AW-1:0] rd_addr;
    t_cmd          cmd;
    logic          has_res;

    function automatic logic [7:0] indent_of(logic signed [DW-1:0] d);
        logic [7:0] u;
        u = 8'd0;
        if (d > 0) begin
            if (d > 255) begin
                u = 8'd255;
            end else begin
                u = 8'(d);
            end
        end
        return u;
    endfunction

    assign i_in.ready = !i_q_full;
    assign fire       = i_in.valid && !i_q_full;
    assign b          = i_in.text_byte;

    always_comb begin
        n_in_quoted = r_in_quoted;
        n_after_bs  = r_after_bs;
        n_key_exp   = r_key_exp;
        n_seen      = r_seen;
        n_depth     = r_depth;
        n_count     = r_count;
        n_top       = r_top;
        stk_push    = 1'b0;
        is_obj      = 1'b0;
        has_res     = 1'b0;
        cmd         = '0;
        if (fire) begin
            if (i_in.op) begin
                if (r_seen) begin
                    has_res       = 1'b1;
                    cmd.slots[0]  = mk_slot(KIND_CRLF, 8'd0);
                    cmd.slots[1]  = mk_attr(i_orig_attr);
                    cmd.last_idx  = SLOT_IW'(1);
                end
                n_in_quoted = 1'b0;
                n_after_bs  = 1'b0;
                n_key_exp   = 1'b0;
                n_seen      = 1'b0;
                n_depth     = '0;
                n_count     = '0;
            end else if (r_in_quoted) begin
                n_seen       = 1'b1;
                has_res      = 1'b1;
                cmd.slots[0] = mk_slot(KIND_CHAR, b);
                if (r_after_bs) begin
                    n_after_bs = 1'b0;
                end else if (b == CH_BSLASH) begin
                    n_after_bs = 1'b1;
                end else if (b == CH_QUOTE) begin
                    cmd.slots[1] = mk_attr(COL_PUNCT);
                    cmd.last_idx = SLOT_IW'(1);
                    n_in_quoted  = 1'b0;
                end
            end else begin
                n_seen  = 1'b1;
                has_res = 1'b1;
                unique case (b) inside
                    CH_LBRACE, CH_LBRACK: begin
                        is_obj = (b == CH_LBRACE);
                        if (r_depth < LIM) begin
                            n_depth = r_depth + DW'(1);
                        end
                        cmd.slots[0] = mk_attr(COL_PUNCT);
                        cmd.slots[1] = mk_slot(KIND_CHAR, b);
                        cmd.slots[2] = mk_slot(KIND_CRLF, 8'd0);
                        cmd.slots[3] = mk_slot(KIND_INDENT, indent_of(n_depth));
                        cmd.last_idx = SLOT_IW'(3);
                        if (r_count < FULL) begin
                            stk_push = 1'b1;
                            n_count  = r_count + CW'(1);
                            n_top    = is_obj;
                        end
                        n_key_exp = is_obj;
                    end
                    CH_RBRACE, CH_RBRACK: begin
                        if (r_depth > -LIM) begin
                            n_depth = r_depth - DW'(1);
                        end
                        cmd.slots[0] = mk_slot(KIND_CRLF, 8'd0);
                        cmd.slots[1] = mk_slot(KIND_INDENT, indent_of(n_depth));
                        cmd.slots[2] = mk_attr(COL_PUNCT);
                        cmd.slots[3] = mk_slot(KIND_CHAR, b);
                        cmd.last_idx = SLOT_IW'(3);
                        if (r_count != '0) begin
                            n_count = r_count - CW'(1);
                            n_top   = r_below;
                        end
                        n_key_exp = 1'b0;
                    end
                    CH_COMMA: begin
                        cmd.slots[0] = mk_attr(COL_PUNCT);
                        cmd.slots[1] = mk_slot(KIND_CHAR, CH_COMMA);
                        cmd.slots[2] = mk_slot(KIND_CRLF, 8'd0);
                        cmd.slots[3] = mk_slot(KIND_INDENT, indent_of(n_depth));
                        cmd.last_idx = SLOT_IW'(3);
                        n_key_exp    = (r_count != '0) && r_top;
                    end
                    CH_COLON: begin
                        cmd.slots[0] = mk_attr(COL_PUNCT);
                        cmd.slots[1] = mk_slot(KIND_CHAR, CH_COLON);
                        cmd.slots[2] = mk_slot(KIND_CHAR, CH_SPACE);
                        cmd.last_idx = SLOT_IW'(2);
                        n_key_exp    = 1'b0;
                    end
                    CH_QUOTE: begin
                        cmd.slots[0] = mk_attr(r_key_exp ? COL_KEY : COL_STRING);
                        cmd.slots[1] = mk_slot(KIND_CHAR, CH_QUOTE);
                        cmd.last_idx = SLOT_IW'(1);
                        n_key_exp    = 1'b0;
                        n_in_quoted  = 1'b1;
                        n_after_bs   = 1'b0;
                    end
                    CH_SPACE, CH_TAB, CH_LF, CH_CR: begin
                        has_res = 1'b0;
                    end
                    [CH_ZERO:CH_NINE], CH_MINUS, CH_DOT: begin
                        cmd.slots[0] = mk_attr(COL_NUMBER);
                        cmd.slots[1] = mk_slot(KIND_CHAR, b);
                        cmd.last_idx = SLOT_IW'(1);
                    end
                    default: begin
                        cmd.slots[0] = mk_attr(COL_LITERAL);
                        cmd.slots[1] = mk_slot(KIND_CHAR, b);
                        cmd.last_idx = SLOT_IW'(1);
                    end
                endcase
            end
        end
    end

    assign o_q_push = has_res;
    assign o_q_cmd  = cmd;

    assign below_idx = n_count - CW'(2);
    assign rd_addr   = (n_count >= CW'(2)) ? below_idx[AW-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (stk_push) begin
            mem[r_count[AW-1:0]] <= is_obj;
        end
        r_below <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quoted <= 1'b0;
            r_after_bs  <= 1'b0;
            r_key_exp   <= 1'b0;
            r_seen      <= 1'b0;
            r_depth     <= '0;
            r_count     <= '0;
            r_top       <= 1'b0;
        end else begin
            r_in_quoted <= n_in_quoted;
            r_after_bs  <= n_after_bs;
            r_key_exp   <= n_key_exp;
            r_seen      <= n_seen;
            r_depth     <= n_depth;
            r_count     <= n_count;
            r_top       <= n_top;
        end
    end

endmodule

/* src/jppc_queue.sv */
// Command queue between front and back: small first-word-fall-through FIFO.
// Uses jppc_pkg.
module jppc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  jppc_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output jppc_pkg::t_cmd o_head,
    input  logic           i_pop
);
    import jppc_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_AW:0]   r_cnt,    n_cnt;
    logic                do_pop;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + QUEUE_AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = r_rd_ptr + QUEUE_AW'(1);
        end
        if (i_push && !do_pop) begin
            n_cnt = r_cnt + (QUEUE_AW+1)'(1);
        end else if (!i_push && do_pop) begin
            n_cnt = r_cnt - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

endmodule

/* src/jppc_back.sv */
// Back end: walks the slots of the head command and presents one result per cycle
// while o_out is ready and a command waits, through an output register. Uses jppc_pkg, jppc_out_if.
module jppc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  jppc_pkg::t_cmd i_q_head,
    output logic           o_q_pop,
    jppc_out_if.source     o_out
);
    import jppc_pkg::*;

    logic               r_valid;
    logic [SLOT_IW-1:0] r_idx;
    logic [1:0]         r_kind;
    logic [7:0]         r_char;
    logic [7:0]         r_units;
    logic [6:0]         r_attr;
    logic               r_last;

    logic  adv;
    logic  load;
    logic  last;
    t_slot slot;

    assign adv     = !r_valid || o_out.ready;
    assign load    = adv && i_q_valid;
    assign slot    = i_q_head.slots[r_idx];
    assign last    = (r_idx == i_q_head.last_idx);
    assign o_q_pop = load && last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind  <= slot.kind;
            r_char  <= (slot.kind == KIND_CHAR)   ? slot.val      : 8'd0;
            r_units <= (slot.kind == KIND_INDENT) ? slot.val      : 8'd0;
            r_attr  <= (slot.kind == KIND_ATTR)   ? slot.val[6:0] : 7'd0;
            r_last  <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (adv) begin
                r_valid <= i_q_valid;
            end
            if (load) begin
                r_idx <= last ? '0 : r_idx + SLOT_IW'(1);
            end
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.kind         = r_kind;
    assign o_out.out_char     = r_char;
    assign o_out.indent_units = r_units;
    assign o_out.attribute    = r_attr;
    assign o_out.last_of_run  = r_last;

endmodule

/* src/json_pretty_print_colorizer.sv */
// Top level of the JSON pretty-print colorizer: APB register, front end,
// command queue and back end. Uses jppc_pkg, jppc_if, jppc_front, jppc_queue, jppc_back.
//
//   channel  dir  handshake      payload
//   i_in     in   valid/ready    op, text_byte
//   o_out    out  valid/ready    kind, out_char, indent_units, attribute, last_of_run
//   apb      in   psel/penable   paddr, pwdata -> prdata, pready
//
// A byte is taken whenever the four-entry command queue has room.
// The back end sends one result per cycle while o_out is ready; a byte causes
// up to four results, and whitespace or an end item after no input cause none.
// Reset is synchronous, active low, and empties the queue and the parse state.
// o_out may stall freely; the queue and output register decouple the two sides.
module json_pretty_print_colorizer #(
    parameter int STACK_DEPTH = 64,
    parameter int DEPTH_LIMIT = 255
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    jppc_in_if.sink                     i_in,
    jppc_out_if.source                  o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [jppc_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import jppc_pkg::*;

    logic [6:0] r_orig_attr;
    logic       q_full;
    logic       q_push;
    t_cmd       q_cmd;
    logic       q_valid;
    t_cmd       q_head;
    logic       q_pop;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_ORIG_ATTR);
    assign prdata  = reg_sel ? {25'd0, r_orig_attr} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orig_attr <= ORIG_ATTR_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_orig_attr <= pwdata[6:0];
        end
    end

    jppc_front #(
        .STACK_DEPTH (STACK_DEPTH),
        .DEPTH_LIMIT (DEPTH_LIMIT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_orig_attr (r_orig_attr),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_cmd)
    );

    jppc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    jppc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule
